[hdl/midi_byte_stream_parser_core_assert.svh]
// assertion macros for the parser core
`ifndef MIDI_BYTE_STREAM_PARSER_CORE_ASSERT_SVH
`define MIDI_BYTE_STREAM_PARSER_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define MBP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// next-cycle implication
`define MBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MBP_ASSERT_IMPLY(label, ante, cons)
`define MBP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/mbp_pkg.sv]
package mbp_pkg;

  localparam int SYSEX_SIZE_DEF = 64;

  // status codes
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_POLY_PRES = 8'hA0;
  localparam logic [7:0] ST_CTRL      = 8'hB0;
  localparam logic [7:0] ST_PROGRAM   = 8'hC0;
  localparam logic [7:0] ST_CHAN_PRES = 8'hD0;
  localparam logic [7:0] ST_BEND      = 8'hE0;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_TIMECODE  = 8'hF1;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_UNDEF_F4  = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5  = 8'hF5;
  localparam logic [7:0] ST_TUNE      = 8'hF6;
  localparam logic [7:0] ST_EOX       = 8'hF7;
  localparam logic [7:0] ST_CLOCK     = 8'hF8;
  localparam logic [7:0] ST_UNDEF_F9  = 8'hF9;
  localparam logic [7:0] ST_START     = 8'hFA;
  localparam logic [7:0] ST_CONTINUE  = 8'hFB;
  localparam logic [7:0] ST_STOP      = 8'hFC;
  localparam logic [7:0] ST_UNDEF_FD  = 8'hFD;
  localparam logic [7:0] ST_SENSING   = 8'hFE;
  localparam logic [7:0] ST_RESET     = 8'hFF;
  localparam logic [7:0] NIBBLE_HI    = 8'hF0;

  localparam logic [4:0]  MAX_CHANNEL     = 5'd16;
  localparam logic [15:0] SENSE_LIMIT_DEF = 16'd300;

  typedef enum logic [1:0] {
    REG_LISTEN_CHANNEL = 2'd0,
    REG_ZERO_VEL_OFF   = 2'd1,
    REG_SENSE_ENABLE   = 2'd2,
    REG_SENSE_LIMIT    = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    SENSE_OFF  = 2'd0,
    SENSE_ON   = 2'd1,
    SENSE_FAIL = 2'd2
  } sense_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_READ = 2'd1,
    FSM_EMIT = 2'd2
  } fsm_t;

  typedef struct packed {
    logic [4:0]  listen_channel;
    logic        zero_velocity_as_off;
    logic        sense_enable;
    logic [15:0] sense_limit;
  } cfg_t;

  typedef struct packed {
    logic        event_res;
    logic [7:0]  msg_type;
    logic [4:0]  msg_channel;
    logic [7:0]  first_data;
    logic [6:0]  second_data;
    logic [6:0]  byte_count;
    logic [31:0] stamp;
    logic [7:0]  sysex_byte;
    logic        last;
  } result_t;

  // message type of a status byte, zero for data and undefined codes
  function automatic logic [7:0] type_of(input logic [7:0] s);
    logic [7:0] r;
    if (!s[7] || s == ST_UNDEF_F4 || s == ST_UNDEF_F5 || s == ST_UNDEF_F9 ||
        s == ST_UNDEF_FD) begin
      r = 8'h00;
    end else if (s < ST_SYSEX) begin
      r = s & NIBBLE_HI;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic is_chan(input logic [7:0] t);
    return t >= ST_NOTE_OFF && t <= ST_BEND && t[3:0] == 4'h0;
  endfunction

endpackage

[hdl/mbp_store.sv]
module mbp_store import mbp_pkg::*; #(
  parameter int DEPTH = SYSEX_SIZE_DEF,
  parameter int AW    = $clog2(SYSEX_SIZE_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/mbp_parser.sv]
module mbp_parser import mbp_pkg::*; #(
  parameter int SYSEX_SIZE = SYSEX_SIZE_DEF,
  parameter int IW = $clog2(SYSEX_SIZE_DEF),
  parameter int LW = $clog2(SYSEX_SIZE_DEF + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          fire,
  input  logic          kind,
  input  logic [7:0]    rx_byte,
  input  logic [31:0]   arrival_time,
  output logic          res_valid,
  output result_t       res,
  output logic          run_go,
  output logic [IW-1:0] run_last_idx,
  output logic [31:0]   first_time,
  output logic          st_we,
  output logic [IW-1:0] st_addr,
  output logic [7:0]    st_data
);

  logic [7:0]    pb0, pb1, pb2, rs;
  logic [7:0]    pb0_next, pb1_next, pb2_next, rs_next;
  logic [IW-1:0] pidx, pidx_next;
  logic [LW-1:0] elen, elen_next;
  logic [31:0]   first_time_next;
  sense_t        sense, sense_next;
  logic [15:0]   ticks, ticks_next;

  logic          d_go;
  logic [7:0]    d_ty, d_d1, d_d2, b0, ty, ty2;
  logic [4:0]    d_ch;
  logic [6:0]    d_cnt;
  logic          use_rs, fail, complete;
  logic [16:0]   n;

  // next state and result of one request
  always_comb begin
    pb0_next = pb0;
    pb1_next = pb1;
    pb2_next = pb2;
    rs_next = rs;
    pidx_next = pidx;
    elen_next = elen;
    first_time_next = first_time;
    sense_next = sense;
    ticks_next = ticks;
    d_go = 1'b0;
    d_ty = 8'h00;
    d_ch = 5'd0;
    d_d1 = 8'h00;
    d_d2 = 8'h00;
    d_cnt = 7'd1;
    fail = 1'b0;
    run_go = 1'b0;
    st_we = 1'b0;
    st_addr = pidx;
    st_data = rx_byte;
    b0 = rx_byte;
    ty = 8'h00;
    use_rs = 1'b0;
    n = {1'b0, ticks} + 17'd1;
    complete = ({1'b0, LW'(pidx)} + {1'b0, LW'(1)}) >= {1'b0, elen};

    if (kind) begin
      // active sensing timeout
      if (cfg.sense_enable && sense == SENSE_ON) begin
        ticks_next = n[16] ? 16'hFFFF : n[15:0];
        if (n > {1'b0, cfg.sense_limit}) begin
          sense_next = SENSE_FAIL;
          fail = 1'b1;
        end
      end
    end else if (cfg.listen_channel <= MAX_CHANNEL) begin
      ticks_next = 16'd0;
      if (pidx == '0) begin
        // message start, possibly with running status
        first_time_next = arrival_time;
        use_rs = is_chan(type_of(rs)) && !rx_byte[7];
        if (use_rs) begin
          b0 = rs;
          pb1_next = rx_byte;
        end
        pb0_next = b0;
        ty = type_of(b0);
        case (ty) inside
          ST_SENSING, ST_TUNE, ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP,
          ST_RESET: begin
            if (ty == ST_SENSING) begin
              sense_next = SENSE_ON;
            end
            pidx_next = '0;
            elen_next = '0;
            d_go = 1'b1;
            d_ty = ty;
          end
          ST_PROGRAM, ST_CHAN_PRES, ST_TIMECODE, ST_SONG_SEL: begin
            if (use_rs) begin
              pidx_next = '0;
              elen_next = '0;
              d_go = 1'b1;
              d_ty = ty;
              d_ch = {1'b0, b0[3:0]} + 5'd1;
              d_d1 = rx_byte;
              d_cnt = 7'd2;
            end else begin
              elen_next = LW'(2);
              pidx_next = IW'(1);
            end
          end
          ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRES, ST_CTRL, ST_BEND,
          ST_SONG_POS: begin
            elen_next = LW'(3);
            pidx_next = use_rs ? IW'(2) : IW'(1);
          end
          ST_SYSEX: begin
            elen_next = LW'(SYSEX_SIZE);
            rs_next = 8'h00;
            st_we = 1'b1;
            st_addr = '0;
            st_data = ST_SYSEX;
            pidx_next = IW'(1);
          end
          default: begin
            pidx_next = '0;
            elen_next = '0;
            rs_next = 8'h00;
          end
        endcase
      end else begin
        case (rx_byte) inside
          // real-time bytes leave the pending message alone
          ST_SENSING, ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_RESET: begin
            if (rx_byte == ST_SENSING) begin
              sense_next = SENSE_ON;
            end
            d_go = 1'b1;
            d_ty = rx_byte;
          end
          ST_EOX: begin
            if (pb0 == ST_SYSEX) begin
              st_we = 1'b1;
              st_data = ST_EOX;
              run_go = 1'b1;
            end
            pidx_next = '0;
            elen_next = '0;
            rs_next = 8'h00;
          end
          default: begin
            if (pb0 == ST_SYSEX) begin
              st_we = 1'b1;
            end else if (pidx == IW'(1)) begin
              pb1_next = rx_byte;
            end else if (pidx == IW'(2)) begin
              pb2_next = rx_byte;
            end
            if (complete) begin
              pidx_next = '0;
              elen_next = '0;
              if (pb0 == ST_SYSEX) begin
                rs_next = 8'h00;
              end else begin
                ty = type_of(pb0);
                rs_next = is_chan(ty) ? pb0 : 8'h00;
                d_go = 1'b1;
                d_ty = ty;
                d_ch = is_chan(ty) ? {1'b0, pb0[3:0]} + 5'd1 : 5'd0;
                d_d1 = pb1_next;
                d_d2 = (elen == LW'(3)) ? pb2_next : 8'h00;
                d_cnt = (elen == LW'(3)) ? 7'd3 : 7'd2;
              end
            end else begin
              pidx_next = pidx + IW'(1);
            end
          end
        endcase
      end
    end

    // zero-velocity conversion and channel filter
    ty2 = (cfg.zero_velocity_as_off && d_ty == ST_NOTE_ON && d_d2 == 8'h00) ?
          ST_NOTE_OFF : d_ty;
    res_valid = fail || (d_go && !(is_chan(ty2) && cfg.listen_channel != 5'd0 &&
                                   d_ch != cfg.listen_channel));
    res.event_res   = fail;
    res.msg_type    = fail ? 8'h00 : ty2;
    res.msg_channel = fail ? 5'd0 : d_ch;
    res.first_data  = fail ? 8'h00 : d_d1;
    res.second_data = fail ? 7'd0 : d_d2[6:0];
    res.byte_count  = fail ? 7'd0 : d_cnt;
    res.stamp       = fail ? 32'd0 : arrival_time;
    res.sysex_byte  = 8'h00;
    res.last        = 1'b1;
  end

  assign run_last_idx = pidx;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      pb0 <= 8'h00;
      pb1 <= 8'h00;
      pb2 <= 8'h00;
      rs <= 8'h00;
      pidx <= '0;
      elen <= '0;
      first_time <= 32'd0;
      sense <= SENSE_OFF;
      ticks <= 16'd0;
    end else if (fire) begin
      pb0 <= pb0_next;
      pb1 <= pb1_next;
      pb2 <= pb2_next;
      rs <= rs_next;
      pidx <= pidx_next;
      elen <= elen_next;
      first_time <= first_time_next;
      sense <= sense_next;
      ticks <= ticks_next;
    end
  end

endmodule

[hdl/midi_byte_stream_parser_core.sv]
// MIDI receive parser: bytes (kind 0) and 1 ms ticks (kind 1) enter as
// requests while the block is idle. A parsed message or an active sensing
// failure lands in a holding stage at the accepting edge and reaches the
// output register as soon as that register is free. A request that gives
// no result can be followed in the next cycle. A request that gives a
// result blocks the input until the result moves on from the holding stage
// to the output register. The next request is taken while the previous
// result still waits unclaimed in the output register. An EOX that closes a
// SysEx message starts a run of one result per stored byte, status and EOX
// included. Each result of the run passes a read state and then an emit
// state, since the SysEx store has a registered read port, and no request
// is taken during the run. The store needs no clearing after reset.
module midi_byte_stream_parser_core import mbp_pkg::*; #(
  parameter int SYSEX_SIZE = SYSEX_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] arrival_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        event_res,
  output logic [7:0]  msg_type,
  output logic [4:0]  msg_channel,
  output logic [7:0]  first_data,
  output logic [6:0]  second_data,
  output logic [6:0]  byte_count,
  output logic [31:0] stamp,
  output logic [7:0]  sysex_byte,
  output logic        last
);

  `include "midi_byte_stream_parser_core_assert.svh"

  localparam int IW = $clog2(SYSEX_SIZE);
  localparam int LW = $clog2(SYSEX_SIZE + 1);

  cfg_t          cfg;
  fsm_t          fsm, fsm_next;
  logic          fire, emit, out_load;
  logic          p_valid, run_go, st_we, rd_en;
  result_t       p_res, pend, out_res, sx_res;
  logic          pend_valid;
  logic [IW-1:0] run_last_idx, run_k, run_last, st_addr;
  logic [7:0]    st_data, rd_data;
  logic [31:0]   first_time;
  logic [LW-1:0] run_len;

  assign in_ready = (fsm == FSM_IDLE) && !pend_valid;
  assign fire = in_valid && in_ready;
  assign emit = (fsm == FSM_EMIT) && !pend_valid;
  assign rd_en = (fsm == FSM_READ);
  assign out_load = pend_valid && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.listen_channel <= 5'd0;
      cfg.zero_velocity_as_off <= 1'b1;
      cfg.sense_enable <= 1'b0;
      cfg.sense_limit <= SENSE_LIMIT_DEF;
    end else if (cfg_wr) begin
      unique case (reg_index_t'(cfg_index))
        REG_LISTEN_CHANNEL: cfg.listen_channel <= cfg_data[4:0];
        REG_ZERO_VEL_OFF:   cfg.zero_velocity_as_off <= cfg_data[0];
        REG_SENSE_ENABLE:   cfg.sense_enable <= cfg_data[0];
        REG_SENSE_LIMIT:    cfg.sense_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  mbp_parser #(.SYSEX_SIZE(SYSEX_SIZE), .IW(IW), .LW(LW)) u_parser (
    .clk, .rst, .cfg, .fire, .kind, .rx_byte, .arrival_time,
    .res_valid(p_valid), .res(p_res), .run_go, .run_last_idx, .first_time,
    .st_we, .st_addr, .st_data
  );

  mbp_store #(.DEPTH(SYSEX_SIZE), .AW(IW)) u_store (
    .clk, .wr_en(st_we && fire), .wr_addr(st_addr), .wr_data(st_data),
    .rd_en, .rd_addr(run_k), .rd_data
  );

  // sysex run result
  assign run_len = LW'(run_last) + LW'(1);
  always_comb begin
    sx_res.event_res   = 1'b0;
    sx_res.msg_type    = ST_SYSEX;
    sx_res.msg_channel = 5'd0;
    sx_res.first_data  = 8'(run_len);
    sx_res.second_data = 7'd0;
    sx_res.byte_count  = 7'(run_len);
    sx_res.stamp       = first_time;
    sx_res.sysex_byte  = rd_data;
    sx_res.last        = (run_k == run_last);
  end

  // run sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= FSM_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      FSM_IDLE: if (fire && run_go) fsm_next = FSM_READ;
      FSM_READ: fsm_next = FSM_EMIT;
      FSM_EMIT: begin
        if (emit) begin
          fsm_next = sx_res.last ? FSM_IDLE : FSM_READ;
        end
      end
      default: fsm_next = FSM_IDLE;
    endcase
  end

  // run counter
  always_ff @(posedge clk) begin
    if (fire && run_go) begin
      run_k <= '0;
      run_last <= run_last_idx;
    end else if (emit) begin
      run_k <= run_k + IW'(1);
    end
  end

  // holding stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        pend_valid <= 1'b0;
      end
      if ((fire && p_valid) || emit) begin
        pend_valid <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && p_valid) begin
      pend <= p_res;
    end else if (emit) begin
      pend <= sx_res;
    end
    if (out_load) begin
      out_res <= pend;
    end
  end

  assign event_res   = out_res.event_res;
  assign msg_type    = out_res.msg_type;
  assign msg_channel = out_res.msg_channel;
  assign first_data  = out_res.first_data;
  assign second_data = out_res.second_data;
  assign byte_count  = out_res.byte_count;
  assign stamp       = out_res.stamp;
  assign sysex_byte  = out_res.sysex_byte;
  assign last        = out_res.last;

  // checks
  `MBP_ASSERT_NEXT(a_pend_kept, pend_valid && !out_load, pend_valid)
  `MBP_ASSERT_IMPLY(a_multi_is_sysex, out_valid && !out_res.last, out_res.msg_type == ST_SYSEX)
  `MBP_ASSERT_IMPLY(a_run_bound, fsm != FSM_IDLE, run_k <= run_last)
  `MBP_ASSERT_NEXT(a_run_start, fire && run_go, fsm == FSM_READ)

endmodule

[tb/midi_byte_stream_parser_core_tb.sv]
module midi_byte_stream_parser_core_tb;
  import mbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = SYSEX_SIZE_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        cfg_wr;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [7:0]  rx_byte;
  logic [31:0] arrival_time;
  logic        out_valid;
  logic        out_ready;
  logic        event_res;
  logic [7:0]  msg_type;
  logic [4:0]  msg_channel;
  logic [7:0]  first_data;
  logic [6:0]  second_data;
  logic [6:0]  byte_count;
  logic [31:0] stamp;
  logic [7:0]  sysex_byte;
  logic        last;

  midi_byte_stream_parser_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .rx_byte(rx_byte), .arrival_time(arrival_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .msg_type(msg_type), .msg_channel(msg_channel),
    .first_data(first_data), .second_data(second_data), .byte_count(byte_count),
    .stamp(stamp), .sysex_byte(sysex_byte), .last(last)
  );

  // expected parser events, oldest first
  result_t expected_events[$];
  int error_count;
  int bytes_sent;
  int ticks_sent;
  int events_seen;
  int sysex_runs;
  int sense_fails;
  bit idle_on;
  bit hold_req;

  // shadow configuration
  logic [4:0]  sh_listen;
  logic        sh_zero_vel;
  logic        sh_sense_en;
  logic [15:0] sh_sense_limit;

  // shadow parser state
  logic [7:0]  msg_buf[3];
  int          buf_pos;
  int          msg_len;
  logic [7:0]  run_status;
  logic [31:0] start_stamp;
  logic [7:0]  sysex_mem[STORE_DEPTH];
  sense_t      sense_st;
  int          sense_count;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // message class of a status byte
  function automatic logic [7:0] status_class(input logic [7:0] s);
    if (s < 8'h80 || s == ST_UNDEF_F4 || s == ST_UNDEF_F5 || s == ST_UNDEF_F9 ||
        s == ST_UNDEF_FD) return 8'h00;
    if (s < ST_SYSEX) return s & NIBBLE_HI;
    return s;
  endfunction

  function automatic bit is_voice(input logic [7:0] t);
    return t >= ST_NOTE_OFF && t <= ST_BEND && t[3:0] == 4'h0;
  endfunction

  task automatic clear_parser();
    buf_pos = 0;
    msg_len = 0;
    run_status = 8'h00;
  endtask

  // conversion, channel filter, then queue one message
  task automatic queue_message(input logic [7:0] ty, input logic [4:0] ch,
                               input logic [7:0] d1, input logic [7:0] d2,
                               input int cnt, input logic [31:0] t);
    result_t r;
    if (sh_zero_vel && ty == ST_NOTE_ON && d2 == 8'h00) ty = ST_NOTE_OFF;
    if (is_voice(ty) && sh_listen != 5'd0 && ch != sh_listen) return;
    r = '0;
    r.msg_type = ty;
    r.msg_channel = ch;
    r.first_data = d1;
    r.second_data = d2[6:0];
    r.byte_count = 7'(cnt);
    r.stamp = t;
    r.last = 1'b1;
    expected_events.push_back(r);
  endtask

  // advance the shadow parser by one request
  task automatic predict_midi_events(input bit k, input logic [7:0] b,
                                     input logic [31:0] t);
    result_t r;
    logic [7:0] ty;
    logic [7:0] d2;
    logic [4:0] ch;
    int idx;
    int len;
    int n;
    if (k) begin
      if (sh_sense_en && sense_st == SENSE_ON) begin
        n = sense_count + 1;
        sense_count = (n > 65535) ? 65535 : n;
        if (n > sh_sense_limit) begin
          sense_st = SENSE_FAIL;
          r = '0;
          r.event_res = 1'b1;
          r.last = 1'b1;
          expected_events.push_back(r);
        end
      end
      return;
    end
    if (sh_listen >= 5'd17) return;
    sense_count = 0;

    // message start
    if (buf_pos == 0) begin
      start_stamp = t;
      msg_buf[0] = b;
      if (is_voice(status_class(run_status)) && b < 8'h80) begin
        msg_buf[0] = run_status;
        msg_buf[1] = b;
        buf_pos = 1;
      end
      ty = status_class(msg_buf[0]);
      case (ty)
        ST_SENSING, ST_TUNE, ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_RESET: begin
          if (ty == ST_SENSING) sense_st = SENSE_ON;
          buf_pos = 0;
          msg_len = 0;
          queue_message(ty, 5'd0, 8'h00, 8'h00, 1, t);
          return;
        end
        ST_PROGRAM, ST_CHAN_PRES, ST_TIMECODE, ST_SONG_SEL: msg_len = 2;
        ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRES, ST_CTRL, ST_BEND, ST_SONG_POS: msg_len = 3;
        ST_SYSEX: begin
          msg_len = STORE_DEPTH;
          run_status = 8'h00;
          sysex_mem[0] = ST_SYSEX;
        end
        default: begin
          clear_parser();
          return;
        end
      endcase
      if (buf_pos >= msg_len - 1) begin
        d2 = (msg_len == 3) ? msg_buf[2] : 8'h00;
        buf_pos = 0;
        len = msg_len;
        msg_len = 0;
        queue_message(ty, 5'(msg_buf[0][3:0]) + 5'd1, msg_buf[1], d2,
                      (len == 3) ? 3 : 2, t);
        return;
      end
      buf_pos++;
      return;
    end

    // inside a pending message
    idx = buf_pos;
    if (b >= 8'h80) begin
      case (b)
        ST_SENSING, ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_RESET: begin
          if (b == ST_SENSING) sense_st = SENSE_ON;
          queue_message(b, 5'd0, 8'h00, 8'h00, 1, t);
          return;
        end
        ST_EOX: begin
          if (msg_buf[0] == ST_SYSEX && idx < STORE_DEPTH) begin
            len = idx + 1;
            sysex_mem[idx] = ST_EOX;
            clear_parser();
            sysex_runs++;
            for (int j = 0; j < len; j++) begin
              r = '0;
              r.msg_type = ST_SYSEX;
              r.first_data = 8'(len);
              r.second_data = 7'(len >> 8);
              r.byte_count = 7'(len);
              r.stamp = start_stamp;
              r.sysex_byte = sysex_mem[j];
              r.last = (j == len - 1);
              expected_events.push_back(r);
            end
            return;
          end
          clear_parser();
          return;
        end
        default: ;
      endcase
    end
    if (msg_buf[0] == ST_SYSEX) begin
      if (idx < STORE_DEPTH) sysex_mem[idx] = b;
    end else if (idx < 3) begin
      msg_buf[idx] = b;
    end
    if (idx >= msg_len - 1) begin
      if (msg_buf[0] == ST_SYSEX) begin
        clear_parser();
        return;
      end
      ty = status_class(msg_buf[0]);
      ch = is_voice(ty) ? 5'(msg_buf[0][3:0]) + 5'd1 : 5'd0;
      d2 = (msg_len == 3) ? msg_buf[2] : 8'h00;
      len = msg_len;
      buf_pos = 0;
      msg_len = 0;
      run_status = is_voice(ty) ? msg_buf[0] : 8'h00;
      queue_message(ty, ch, msg_buf[1], d2, (len == 3) ? 3 : 2, t);
      return;
    end
    buf_pos++;
  endtask

  // one request on the input channel; valid stays up for a following request
  task automatic send_item(input bit k, input logic [7:0] b);
    logic [31:0] t;
    t = $urandom;
    @(negedge clk);
    if (idle_on && $urandom_range(99) < 11) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    rx_byte = b;
    arrival_time = t;
    do @(posedge clk); while (!in_ready);
    predict_midi_events(k, b, t);
    if (k) ticks_sent++;
    else bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(1'b1, 8'($urandom));
  endtask

  // drop valid and wait for every expected event plus the block's latency
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // register write once nothing is in flight
  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    wait_drain();
    @(negedge clk);
    cfg_wr = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr = 1'b0;
    case (idx)
      REG_LISTEN_CHANNEL: sh_listen = val[4:0];
      REG_ZERO_VEL_OFF:   sh_zero_vel = val[0];
      REG_SENSE_ENABLE:   sh_sense_en = val[0];
      REG_SENSE_LIMIT:    sh_sense_limit = val;
      default: ;
    endcase
  endtask

  task automatic send_voice(input logic [7:0] st, input logic [7:0] d1,
                            input logic [7:0] d2);
    send_byte(st);
    send_byte(d1);
    if (status_class(st) != ST_PROGRAM && status_class(st) != ST_CHAN_PRES) send_byte(d2);
  endtask

  // note, program and running status forms, channel extremes, zero velocity
  task automatic test_channel_messages();
    send_voice(ST_NOTE_ON, 8'h00, 8'h7F);
    send_voice(ST_NOTE_ON | 8'h0F, 8'h7F, 8'h00);
    send_byte(8'h40);
    send_byte(8'h00);
    send_voice(ST_PROGRAM | 8'h03, 8'h12, 8'h00);
    send_byte(8'h34);
    send_voice(ST_BEND | 8'h05, 8'h7F, 8'h7F);
    write_reg(REG_ZERO_VEL_OFF, 16'd0);
    send_voice(ST_NOTE_ON, 8'h3C, 8'h00);
    wait_drain();
    write_reg(REG_ZERO_VEL_OFF, 16'd1);
  endtask

  // real-time inside a message, undefined and stray status, data without status
  task automatic test_realtime_and_stray();
    send_byte(ST_SONG_SEL);
    send_byte(8'h05);
    send_byte(8'h22);
    send_byte(ST_UNDEF_F4);
    send_byte(ST_UNDEF_FD);
    send_byte(ST_CTRL | 8'h02);
    send_byte(ST_CLOCK);
    send_byte(ST_TUNE);
    send_byte(8'h07);
    send_byte(ST_EOX);
    send_byte(ST_SONG_POS);
    send_byte(ST_NOTE_OFF);
    send_byte(ST_RESET);
    send_byte(8'h11);
    send_byte(ST_EOX);
    wait_drain();
  endtask

  // short message, real-time inside, the largest message and one overflow
  task automatic test_sysex();
    send_byte(ST_SYSEX);
    send_byte(ST_EOX);
    send_byte(ST_SYSEX);
    send_byte(8'h7E);
    send_byte(ST_START);
    send_byte(ST_NOTE_ON);
    send_byte(8'hFF & 8'h7F);
    send_byte(ST_EOX);
    send_byte(ST_SYSEX);
    repeat (STORE_DEPTH - 2) send_byte(8'($urandom_range(0, 127)));
    send_byte(ST_EOX);
    send_byte(ST_SYSEX);
    repeat (STORE_DEPTH - 1) send_byte(8'($urandom_range(0, 127)));
    send_byte(ST_EOX);
    wait_drain();
  endtask

  // single channel, input off and omni again
  task automatic test_channel_filter();
    write_reg(REG_LISTEN_CHANNEL, 16'd16);
    send_voice(ST_NOTE_ON | 8'h0F, 8'h10, 8'h20);
    send_voice(ST_NOTE_ON | 8'h00, 8'h10, 8'h20);
    send_byte(ST_STOP);
    wait_drain();
    write_reg(REG_LISTEN_CHANNEL, 16'd1);
    send_voice(ST_CTRL, 8'h07, 8'h64);
    send_voice(ST_CTRL | 8'h01, 8'h07, 8'h64);
    wait_drain();
    write_reg(REG_LISTEN_CHANNEL, 16'd17);
    send_voice(ST_NOTE_ON, 8'h10, 8'h20);
    send_byte(ST_SENSING);
    wait_drain();
    write_reg(REG_LISTEN_CHANNEL, 16'd0);
  endtask

  // active sensing timeout at the smallest and largest limits
  task automatic test_sensing();
    send_ticks(2);
    write_reg(REG_SENSE_ENABLE, 16'd1);
    write_reg(REG_SENSE_LIMIT, 16'd1);
    send_byte(ST_SENSING);
    send_ticks(4);
    send_byte(ST_SENSING);
    send_ticks(1);
    send_byte(ST_CLOCK);
    send_ticks(3);
    wait_drain();
    write_reg(REG_SENSE_LIMIT, 16'd65535);
    send_byte(ST_SENSING);
    send_ticks(10);
    wait_drain();
    write_reg(REG_SENSE_ENABLE, 16'd0);
    send_ticks(2);
    wait_drain();
  endtask

  // one random message, mostly well formed
  task automatic send_random_message();
    int sel;
    logic [7:0] st;
    sel = $urandom_range(99);
    if (sel < 30) begin
      st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
      send_byte(st);
      if ($urandom_range(9) == 0) send_byte(ST_CLOCK);
      send_byte(8'($urandom_range(0, 127)));
      if (status_class(st) != ST_PROGRAM && status_class(st) != ST_CHAN_PRES)
        send_byte(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(0, 127)));
    end else if (sel < 45) begin
      repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 127)));
    end else if (sel < 53) begin
      st = ST_TIMECODE + 8'($urandom_range(0, 2));
      send_byte(st);
      repeat ((st == ST_SONG_POS) ? 2 : 1) send_byte(8'($urandom_range(0, 127)));
    end else if (sel < 63) begin
      send_byte(8'hF8 + 8'($urandom_range(0, 7)));
    end else if (sel < 73) begin
      send_byte(ST_SYSEX);
      repeat (($urandom_range(9) == 0) ? $urandom_range(58, 66) : $urandom_range(0, 8)) begin
        if ($urandom_range(19) == 0) send_byte(ST_SENSING);
        else send_byte(8'($urandom_range(0, 127)));
      end
      send_byte(ST_EOX);
    end else if (sel < 83) begin
      send_ticks($urandom_range(1, 6));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // random phases under changing settings, one longer phase with no idling
  task automatic test_random();
    int start;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_LISTEN_CHANNEL, ($urandom_range(4) == 0) ? 16'($urandom_range(1, 16)) :
                (ph == 3) ? 16'd17 : 16'd0);
      write_reg(REG_ZERO_VEL_OFF, 16'($urandom_range(0, 1)));
      write_reg(REG_SENSE_ENABLE, 16'($urandom_range(0, 1)));
      write_reg(REG_SENSE_LIMIT, (ph == 1) ? 16'd65535 : 16'($urandom_range(1, 5)));
      idle_on = (ph != 2);
      start = bytes_sent + ticks_sent;
      while (bytes_sent + ticks_sent - start < ((ph == 2) ? 30 : 5)) send_random_message();
      wait_drain();
    end
    idle_on = 1'b1;
  endtask

  // receiver holds off long while notes keep coming, then the sender waits
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (6) send_voice(ST_NOTE_ON | 8'($urandom_range(0, 15)),
                          8'($urandom_range(0, 127)), 8'($urandom_range(1, 127)));
    wait_drain();
  endtask

  // receiver side
  always begin
    @(negedge clk);
    if (hold_req) begin
      out_ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end
    out_ready = !idle_on || ($urandom_range(99) >= 11);
  end

  // compare each event with the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        $error("unexpected event, msg_type %h", msg_type);
        error_count++;
      end else begin
        e = expected_events.pop_front();
        if (event_res !== e.event_res) begin
          $error("event_res exp %h got %h", e.event_res, event_res); error_count++;
        end
        if (msg_type !== e.msg_type) begin
          $error("msg_type exp %h got %h", e.msg_type, msg_type); error_count++;
        end
        if (msg_channel !== e.msg_channel) begin
          $error("msg_channel exp %0d got %0d", e.msg_channel, msg_channel); error_count++;
        end
        if (first_data !== e.first_data) begin
          $error("first_data exp %h got %h", e.first_data, first_data); error_count++;
        end
        if (second_data !== e.second_data) begin
          $error("second_data exp %h got %h", e.second_data, second_data); error_count++;
        end
        if (byte_count !== e.byte_count) begin
          $error("byte_count exp %0d got %0d", e.byte_count, byte_count); error_count++;
        end
        if (stamp !== e.stamp) begin
          $error("stamp exp %h got %h", e.stamp, stamp); error_count++;
        end
        if (sysex_byte !== e.sysex_byte) begin
          $error("sysex_byte exp %h got %h", e.sysex_byte, sysex_byte); error_count++;
        end
        if (last !== e.last) begin
          $error("last exp %h got %h", e.last, last); error_count++;
        end
        if (e.event_res) sense_fails++;
      end
    end
  end

  // watchdog on cycles with no traffic
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr = 1'b0;
    cfg_index = REG_LISTEN_CHANNEL;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = 1'b0;
    rx_byte = '0;
    arrival_time = '0;
    out_ready = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    error_count = 0;
    bytes_sent = 0;
    ticks_sent = 0;
    events_seen = 0;
    sysex_runs = 0;
    sense_fails = 0;
    sh_listen = 5'd0;
    sh_zero_vel = 1'b1;
    sh_sense_en = 1'b0;
    sh_sense_limit = SENSE_LIMIT_DEF;
    msg_buf = '{8'h00, 8'h00, 8'h00};
    clear_parser();
    start_stamp = '0;
    sense_st = SENSE_OFF;
    sense_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_channel_messages();
    test_realtime_and_stray();
    test_sysex();
    test_channel_filter();
    test_sensing();
    test_random();
    test_backpressure();
    wait_drain();

    $display("covered %0d bytes and %0d ticks, %0d events checked", bytes_sent,
             ticks_sent, events_seen);
    $display("including %0d sysex runs and %0d sensing timeouts", sysex_runs,
             sense_fails);
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
